// File: sv/itda_pkg.sv
// ----------------------------------------------------------------------------
// itda_pkg
// shared types and constants for the integer to decimal ascii converter
// ----------------------------------------------------------------------------
`default_nettype none

package itda_pkg;

  localparam int DEF_VALUE_BITS  = 64;
  localparam int DEC_DIGITS      = 20;
  localparam int BCD_W           = 4 * DEC_DIGITS;
  localparam int DIGIT_IDX_W     = $clog2(DEC_DIGITS);
  localparam int ITERS_PER_STAGE = 8;

  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] MINUS_CHAR = 8'd45;
  localparam logic [3:0] DEC_BASE   = 4'd10;

  typedef struct packed {
    logic [63:0] number;
    logic        signed_mode;
  } num_item_t;

  typedef struct packed {
    logic [7:0] ascii_char;
    logic       last_char;
  } txt_item_t;

endpackage

`default_nettype wire

// File: sv/itda_front.sv
// ----------------------------------------------------------------------------
// itda_front
// input stage: trims to the value width and forms sign and magnitude
// ----------------------------------------------------------------------------
`default_nettype none

module itda_front import itda_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire num_item_t             in_item,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic [VALUE_BITS-1:0] out_mag,
  output      logic                  out_neg
);

  logic [VALUE_BITS-1:0] raw;
  logic                  neg_next;

  assign raw      = in_item.number[VALUE_BITS-1:0];
  assign neg_next = in_item.signed_mode & raw[VALUE_BITS-1];
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_neg <= neg_next;
      out_mag <= neg_next ? (~raw + 1'b1) : raw;
    end
  end

endmodule

`default_nettype wire

// File: sv/itda_dabble_stage.sv
// ----------------------------------------------------------------------------
// itda_dabble_stage
// one pipeline stage of shift-add-3 binary to bcd conversion
// ----------------------------------------------------------------------------
`default_nettype none

module itda_dabble_stage import itda_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int ITERS      = ITERS_PER_STAGE
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic [BCD_W-1:0]      in_bcd,
  input  wire logic [VALUE_BITS-1:0] in_bin,
  input  wire logic                  in_neg,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic [BCD_W-1:0]      out_bcd,
  output      logic [VALUE_BITS-1:0] out_bin,
  output      logic                  out_neg
);

  logic [BCD_W-1:0]      bcd_next;
  logic [VALUE_BITS-1:0] bin_next;

  // adjust digits of five or more, then shift one binary bit in
  always_comb begin
    bcd_next = in_bcd;
    bin_next = in_bin;
    for (int it = 0; it < ITERS; it++) begin
      for (int d = 0; d < DEC_DIGITS; d++) begin
        if (bcd_next[4*d +: 4] >= 4'd5) begin
          bcd_next[4*d +: 4] = bcd_next[4*d +: 4] + 4'd3;
        end
      end
      bcd_next = {bcd_next[BCD_W-2:0], bin_next[VALUE_BITS-1]};
      bin_next = {bin_next[VALUE_BITS-2:0], 1'b0};
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_bcd <= bcd_next;
      out_bin <= bin_next;
      out_neg <= in_neg;
    end
  end

endmodule

`default_nettype wire

// File: sv/itda_emit.sv
// ----------------------------------------------------------------------------
// itda_emit
// character serializer: sign, then digits from the leading nonzero one
// ----------------------------------------------------------------------------
`default_nettype none

module itda_emit import itda_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire logic [BCD_W-1:0] in_bcd,
  input  wire logic             in_neg,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      txt_item_t        out_item
);

  logic                   busy;
  logic                   sign_pend;
  logic [DIGIT_IDX_W-1:0] pos;
  logic [BCD_W-1:0]       bcd;
  logic [DIGIT_IDX_W-1:0] lead;
  logic                   out_free;
  logic [3:0]             digit;

  // highest nonzero digit, zero when the value is zero
  always_comb begin
    lead = '0;
    for (int d = 0; d < DEC_DIGITS; d++) begin
      if (in_bcd[4*d +: 4] != 4'd0) begin
        lead = DIGIT_IDX_W'(d);
      end
    end
  end

  assign in_ready = !busy;
  assign out_free = !out_valid || out_ready;
  assign digit    = bcd[4*pos +: 4];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      sign_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (busy && out_free) begin
        out_valid <= 1'b1;
        if (sign_pend) begin
          sign_pend <= 1'b0;
        end else if (pos == '0) begin
          busy <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_valid && !busy) begin
        busy      <= 1'b1;
        sign_pend <= in_neg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !busy) begin
      bcd <= in_bcd;
      pos <= lead;
    end else if (busy && out_free) begin
      if (sign_pend) begin
        out_item.ascii_char <= MINUS_CHAR;
        out_item.last_char  <= 1'b0;
      end else begin
        out_item.ascii_char <= ASCII_ZERO + {4'b0, digit};
        out_item.last_char  <= (pos == '0);
        pos                 <= pos - 1'b1;
      end
    end
  end

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.ascii_char == MINUS_CHAR |-> !out_item.last_char)
    else $error("minus sign marked as last character");

  a_char_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.ascii_char == MINUS_CHAR ||
                  (out_item.ascii_char >= ASCII_ZERO &&
                   out_item.ascii_char < ASCII_ZERO + {4'b0, DEC_BASE}))
    else $error("character is neither a digit nor a minus sign");

  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> busy)
    else $error("loaded item did not start emission");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    busy && out_free && !sign_pend && pos == '0 |=> out_item.last_char)
    else $error("final digit not marked last");

endmodule

`default_nettype wire

// File: sv/integer_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii
// binary integer to decimal ascii text, one character per output item
// ----------------------------------------------------------------------------
// path: the first character passes the front stage, the shift-add-3 stages of
//   up to eight bits each, the emitter load and the output register
// throughput: the emitter sends one character per cycle while txt_ready does not
//   stall it; it loads a new item only after the last character of the one before
// reset: synchronous, clears all valid bits and the emitter; no memories
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_decimal_ascii import itda_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      num_valid,
  output      logic      num_ready,
  input  wire num_item_t num,
  output      logic      txt_valid,
  input  wire logic      txt_ready,
  output      txt_item_t txt
);

  // number of shift-add-3 stages, up to eight binary bits each
  localparam int NSTG = (VALUE_BITS + ITERS_PER_STAGE - 1) / ITERS_PER_STAGE;

  // pipeline links: index 0 is the front stage output
  logic                  vld [NSTG+1];
  logic                  rdy [NSTG+1];
  logic [BCD_W-1:0]      bcd [NSTG+1];
  logic [VALUE_BITS-1:0] bin [NSTG+1];
  logic                  neg [NSTG+1];

  // front: trim, sign detect, negate to magnitude
  itda_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (num_valid),
    .in_ready (num_ready),
    .in_item  (num),
    .out_valid(vld[0]),
    .out_ready(rdy[0]),
    .out_mag  (bin[0]),
    .out_neg  (neg[0])
  );

  // bcd accumulator starts empty
  assign bcd[0] = '0;

  // shift-add-3 chain, the last stage may take fewer than eight bits
  for (genvar g = 0; g < NSTG; g++) begin : g_stage
    localparam int LEFT  = VALUE_BITS - g * ITERS_PER_STAGE;
    localparam int ITERS = (LEFT < ITERS_PER_STAGE) ? LEFT : ITERS_PER_STAGE;

    itda_dabble_stage #(
      .VALUE_BITS(VALUE_BITS),
      .ITERS     (ITERS)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_valid (vld[g]),
      .in_ready (rdy[g]),
      .in_bcd   (bcd[g]),
      .in_bin   (bin[g]),
      .in_neg   (neg[g]),
      .out_valid(vld[g+1]),
      .out_ready(rdy[g+1]),
      .out_bcd  (bcd[g+1]),
      .out_bin  (bin[g+1]),
      .out_neg  (neg[g+1])
    );
  end

  // serializer with its own output register
  itda_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld[NSTG]),
    .in_ready (rdy[NSTG]),
    .in_bcd   (bcd[NSTG]),
    .in_neg   (neg[NSTG]),
    .out_valid(txt_valid),
    .out_ready(txt_ready),
    .out_item (txt)
  );

endmodule

`default_nettype wire
